[rtl/sffa_pkg.sv]
// ----------------------------------------------------------------------------
// Segment first-fit allocator package
// Shared constants, status codes and interface types of the allocator.
// ----------------------------------------------------------------------------
package sffa_pkg;

  localparam int unsigned MAX_BLOCKS = 16;
  localparam int unsigned IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PAGE_W     = 20;
  localparam int unsigned ENTRY_W    = 2 * PAGE_W;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_SIZE  = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_OUTSIDE  = 3'd2;
  localparam logic [2:0] ST_OVERLAP  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic OP_ANYWHERE = 1'b0;
  localparam logic OP_FIXED    = 1'b1;

  typedef struct packed {
    logic [31:0]       start_byte;
    logic [PAGE_W:0]   start_pg;
    logic [PAGE_W:0]   limit_pg;
  } sffa_seg_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } sffa_mem_req_t;

endpackage

[rtl/sffa_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sffa_ctrl.sv]
// ----------------------------------------------------------------------------
// Allocator sequencer
// Checks a request, scans the block table in RAM for overlaps, moves an
// anywhere candidate on each hit (a fixed request fails with an overlap status)
// and records the granted block.
module sffa_ctrl (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  opcode_i,
  input  logic [31:0]                           request_size_i,
  input  logic [31:0]                           alignment_i,
  input  logic [31:0]                           fixed_address_i,
  input  sffa_pkg::sffa_seg_t                   seg_i,
  output sffa_pkg::sffa_mem_req_t               mem_o,
  input  logic [sffa_pkg::ENTRY_W-1:0]          rdata_i,
  output logic                                  busy_o,
  output logic                                  done_o,
  output logic [31:0]                           granted_address_o,
  output logic [31:0]                           granted_size_o,
  output logic [2:0]                            status_o
);
  import sffa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LIMIT,
    S_SCAN,
    S_ALIGN,
    S_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic              op_q, op_d;
  logic [PAGE_W:0]   pages_q, pages_d;
  logic [18:0]       am1_q, am1_d;
  logic [PAGE_W-1:0] fpage_q, fpage_d;
  logic [21:0]       cand_q, cand_d;
  logic [PAGE_W:0]   end_q, end_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [2:0]        status_q, status_d;
  logic              done_q, done_d;
  logic [31:0]       gaddr_q, gaddr_d;
  logic [31:0]       gsize_q, gsize_d;

  logic [32:0]       page_sum;
  logic [31:0]       smear;
  logic [21:0]       align_start;
  logic [22:0]       align_end;
  logic [22:0]       hi_pg;
  logic [PAGE_W-1:0] rd_base;
  logic [PAGE_W-1:0] rd_pages;
  logic [22:0]       rd_end;
  logic              hit;

  always_comb begin
    smear = alignment_i | (alignment_i >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
  end

  assign page_sum = {1'b0, request_size_i} + 33'd4095 +
                    ((opcode_i == OP_FIXED) ? {21'd0, fixed_address_i[11:0]} : 33'd0);

  assign align_start = ({1'b0, seg_i.start_pg} + {3'd0, am1_q}) & ~{3'd0, am1_q};
  assign align_end   = ({2'd0, end_q} + {4'd0, am1_q}) & ~{4'd0, am1_q};
  assign hi_pg       = {1'b0, cand_q} + {2'd0, pages_q};
  assign rd_base     = rdata_i[ENTRY_W-1:PAGE_W];
  assign rd_pages    = rdata_i[PAGE_W-1:0];
  assign rd_end      = {3'd0, rd_base} + {3'd0, rd_pages};
  assign hit         = pend_q && ({3'd0, rd_base} < hi_pg) && ({1'b0, cand_q} < rd_end);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    pages_d  = pages_q;
    am1_d    = am1_q;
    fpage_d  = fpage_q;
    cand_d   = cand_q;
    end_d    = end_q;
    idx_d    = idx_q;
    pend_d   = 1'b0;
    count_d  = count_q;
    status_d = status_q;
    done_d   = 1'b0;
    gaddr_d  = gaddr_q;
    gsize_d  = gsize_q;
    mem_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = opcode_i;
          pages_d = page_sum[32:12];
          am1_d   = (alignment_i > 32'd4096) ? smear[31:13] : 19'd0;
          fpage_d = fixed_address_i[31:12];
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        state_d = S_FINISH;
        if (count_q == CNT_W'(MAX_BLOCKS)) begin
          status_d = ST_FULL;
        end else if (pages_q == '0) begin
          status_d = ST_NO_SPACE;
        end else if (pages_q[PAGE_W]) begin
          status_d = (op_q == OP_FIXED) ? ST_OUTSIDE : ST_NO_SPACE;
        end else if (op_q == OP_FIXED) begin
          if ({fpage_q, 12'd0} < seg_i.start_byte) begin
            status_d = ST_OUTSIDE;
          end else begin
            cand_d  = {2'd0, fpage_q};
            state_d = S_LIMIT;
          end
        end else begin
          cand_d  = align_start;
          state_d = S_LIMIT;
        end
      end
      S_LIMIT: begin
        if (hi_pg > {2'd0, seg_i.limit_pg}) begin
          status_d = (op_q == OP_FIXED) ? ST_OUTSIDE : ST_NO_SPACE;
          state_d  = S_FINISH;
        end else begin
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          end_d = rd_end[PAGE_W:0];
          if (op_q == OP_FIXED) begin
            status_d = ST_OVERLAP;
            state_d  = S_FINISH;
          end else begin
            state_d = S_ALIGN;
          end
        end else if (idx_q < count_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = idx_q[IDX_W-1:0];
          idx_d       = idx_q + 1'b1;
          pend_d      = 1'b1;
        end else if (!pend_q) begin
          status_d = ST_OK;
          state_d  = S_FINISH;
        end
      end
      S_ALIGN: begin
        cand_d  = align_end[21:0];
        state_d = S_LIMIT;
      end
      S_FINISH: begin
        done_d = 1'b1;
        if (status_q == ST_OK) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = count_q[IDX_W-1:0];
          mem_o.wdata = {cand_q[PAGE_W-1:0], pages_q[PAGE_W-1:0]};
          count_d     = count_q + 1'b1;
          gaddr_d     = {cand_q[PAGE_W-1:0], 12'd0};
          gsize_d     = {pages_q[PAGE_W-1:0], 12'd0};
        end else begin
          gaddr_d = '0;
          gsize_d = '0;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    pages_q <= pages_d;
    am1_q   <= am1_d;
    fpage_q <= fpage_d;
    cand_q  <= cand_d;
    end_q   <= end_d;
    gaddr_q <= gaddr_d;
    gsize_q <= gsize_d;
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign granted_address_o = gaddr_q;
  assign granted_size_o    = gsize_q;
  assign status_o          = status_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_BLOCKS))
    else $error("block count exceeds table depth");

  a_grow_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_OK) |-> count_q == $past(count_q) + 1'b1)
    else $error("granted block was not recorded");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != ST_OK) |-> (gaddr_q == '0 && gsize_q == '0))
    else $error("failed transfer carries a nonzero address or size");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.we |-> count_q < CNT_W'(MAX_BLOCKS))
    else $error("table write while full");
`endif

endmodule

[rtl/segment_first_fit_allocator_top.sv]
// ----------------------------------------------------------------------------
// Segment first-fit allocator
// The table is scanned anew for each candidate position; done rises once a scan
// finds no overlap or the request fails. One request at a time; the next start
// is taken in the cycle of the strobe. The table scan reads one RAM entry per
// cycle until a hit.
// Reset clears the block count and both segment registers; table RAM is kept.
// The result is shown for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module segment_first_fit_allocator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sffa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_wdata_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           opcode_i,
  input  logic [31:0]                    request_size_i,
  input  logic [31:0]                    alignment_i,
  input  logic [31:0]                    fixed_address_i,
  output logic                           done_o,
  output logic [31:0]                    granted_address_o,
  output logic [31:0]                    granted_size_o,
  output logic [2:0]                     status_o
);
  import sffa_pkg::*;

  logic [31:0]        seg_start_q;
  logic [31:0]        seg_size_q;
  logic [32:0]        seg_end;
  logic [32:0]        start_round;
  sffa_seg_t          seg;
  sffa_mem_req_t      mem_req;
  logic [ENTRY_W-1:0] rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_start_q <= '0;
      seg_size_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SEG_START: seg_start_q <= cfg_wdata_i;
        CFG_SEG_SIZE:  seg_size_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign seg_end     = {1'b0, seg_start_q} + {1'b0, seg_size_q};
  assign start_round = {1'b0, seg_start_q} + 33'd4095;

  always_comb begin
    seg.start_byte = seg_start_q;
    seg.start_pg   = start_round[32:12];
    seg.limit_pg   = seg_end[32] ? {1'b1, {PAGE_W{1'b0}}} : {1'b0, seg_end[31:12]};
  end

  sffa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  sffa_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .opcode_i          (opcode_i),
    .request_size_i    (request_size_i),
    .alignment_i       (alignment_i),
    .fixed_address_i   (fixed_address_i),
    .seg_i             (seg),
    .mem_o             (mem_req),
    .rdata_i           (rdata),
    .busy_o            (busy_o),
    .done_o            (done_o),
    .granted_address_o (granted_address_o),
    .granted_size_o    (granted_size_o),
    .status_o          (status_o)
  );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment first-fit allocator testbench
// Sends allocation requests through the start/busy handshake and predicts
// every grant with a local model of the block table and segment registers.
// Each done strobe is checked against the oldest predicted grant. A short
// directed part covers the segment edges, oversize requests, alignment and
// overlap cases. Random phases follow, each with a new segment setting. The
// stimulus is steered so that the table fills slowly over the run.
// ----------------------------------------------------------------------------
module tb_top;
  import sffa_pkg::*;

  localparam int unsigned PAGE        = 4096;
  localparam bit [63:0]   PAGE_LIMIT  = 64'h0000_0000_000F_FFFF;
  localparam bit [63:0]   PAGE_MASK   = 64'hFFFF_FFFF_FFFF_F000;
  localparam bit [63:0]   ADDR_TOP    = 64'h0000_0001_0000_0000;
  localparam int          PHASES      = 82;
  localparam int          PHASE_LEN   = 20;
  localparam int          FILL_PHASE  = 74;
  localparam int          IDLE_LIMIT  = 4000;
  localparam int          TAIL_CYCLES = 400;
  localparam int          MAX_PRINTS  = 40;

  typedef struct packed {
    logic        op;
    logic [31:0] req_size;
    logic [31:0] req_align;
    logic [31:0] fixed_addr;
  } alloc_req_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] size;
    logic [2:0]  status;
  } grant_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i       = '0;
  logic [31:0]          cfg_wdata_i     = '0;
  logic                 start_i         = 1'b0;
  logic                 opcode_i        = 1'b0;
  logic [31:0]          request_size_i  = '0;
  logic [31:0]          alignment_i     = '0;
  logic [31:0]          fixed_address_i = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [31:0]          granted_address_o;
  logic [31:0]          granted_size_o;
  logic [2:0]           status_o;

  bit [PAGE_W-1:0] tbl_base  [MAX_BLOCKS];
  bit [PAGE_W-1:0] tbl_pages [MAX_BLOCKS];
  int              tbl_count;
  bit [31:0]       seg_start_q;
  bit [31:0]       seg_size_q;

  alloc_req_t  pending_reqs [$];
  grant_t      grants_due [$];
  alloc_req_t  cur_req;
  grant_t      got_grant;
  int unsigned gap_left;
  bit          no_gaps;
  int          requests_posted;
  int          requests_taken;
  int          results_seen;
  int          error_count;
  int          segments_set;
  int          idle_cycles;
  int          status_seen [5];

  segment_first_fit_allocator_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .opcode_i          (opcode_i),
    .request_size_i    (request_size_i),
    .alignment_i       (alignment_i),
    .fixed_address_i   (fixed_address_i),
    .done_o            (done_o),
    .granted_address_o (granted_address_o),
    .granted_size_o    (granted_size_o),
    .status_o          (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic bit [63:0] segment_end();
    bit [63:0] lim;
    lim = {32'd0, seg_start_q} + {32'd0, seg_size_q};
    if (lim > ADDR_TOP) lim = ADDR_TOP;
    return lim;
  endfunction

  function automatic bit find_hit(input bit [63:0] lo, input bit [63:0] hi,
                                  output bit [63:0] stop);
    bit [63:0] b;
    bit [63:0] e;
    bit        hit;
    hit  = 1'b0;
    stop = '0;
    for (int i = 0; i < tbl_count && !hit; i++) begin
      b = {44'd0, tbl_base[i]} * PAGE;
      e = b + {44'd0, tbl_pages[i]} * PAGE;
      if (b < hi && lo < e) begin
        hit  = 1'b1;
        stop = e;
      end
    end
    return hit;
  endfunction

  function automatic grant_t plan_grant(input alloc_req_t r);
    grant_t    g;
    bit [63:0] lim;
    bit [63:0] a;
    bit [63:0] mask;
    bit [63:0] pages;
    bit [63:0] bytes;
    bit [63:0] cand;
    bit [63:0] addr;
    bit [63:0] stop;
    bit        found;
    g        = '0;
    g.status = ST_OK;
    addr     = '0;
    pages    = '0;
    lim      = segment_end();
    if (tbl_count >= MAX_BLOCKS) begin
      g.status = ST_FULL;
    end else if (r.op == OP_ANYWHERE) begin
      a = PAGE;
      if (r.req_align > PAGE) begin
        a = 1;
        while ((a << 1) <= {32'd0, r.req_align}) a = a << 1;
      end
      mask  = ~(a - 1);
      pages = ({32'd0, r.req_size} + PAGE - 1) / PAGE;
      if (pages == 0 || pages > PAGE_LIMIT) begin
        g.status = ST_NO_SPACE;
      end else begin
        bytes = pages * PAGE;
        cand  = ({32'd0, seg_start_q} + a - 1) & mask;
        found = 1'b0;
        while (!found && cand + bytes <= lim) begin
          if (!find_hit(cand, cand + bytes, stop)) begin
            addr  = cand;
            found = 1'b1;
          end else begin
            cand = (stop + a - 1) & mask;
          end
        end
        if (!found) g.status = ST_NO_SPACE;
      end
    end else begin
      addr  = {32'd0, r.fixed_addr} & PAGE_MASK;
      pages = ({52'd0, r.fixed_addr[11:0]} + {32'd0, r.req_size} + PAGE - 1) / PAGE;
      if (pages == 0) begin
        g.status = ST_NO_SPACE;
      end else if (pages > PAGE_LIMIT || addr < {32'd0, seg_start_q} ||
                   addr + pages * PAGE > lim) begin
        g.status = ST_OUTSIDE;
      end else if (find_hit(addr, addr + pages * PAGE, stop)) begin
        g.status = ST_OVERLAP;
      end
    end
    if (g.status == ST_OK) begin
      g.addr = addr[31:0];
      g.size = 32'(pages * PAGE);
    end
    return g;
  endfunction

  task automatic predict_grant(input alloc_req_t r);
    grant_t g;
    g = plan_grant(r);
    if (g.status == ST_OK) begin
      tbl_base[tbl_count]  = g.addr[31:12];
      tbl_pages[tbl_count] = g.size[31:12];
      tbl_count++;
    end
    status_seen[g.status]++;
    grants_due.push_back(g);
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic int unsigned draw_gap();
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 30);
    return $urandom_range(50, 300);
  endfunction

  // Request driver: one transfer per edge with start high and busy low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_grant(cur_req);
        requests_taken++;
      end
      if (!start_i || !busy_o) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req          = pending_reqs.pop_front();
          opcode_i        <= cur_req.op;
          request_size_i  <= cur_req.req_size;
          alignment_i     <= cur_req.req_align;
          fixed_address_i <= cur_req.fixed_addr;
          start_i         <= 1'b1;
          gap_left         = draw_gap();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Grant monitor.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (grants_due.size() == 0) begin
        report_mismatch($sformatf("grant %h/%h status %0d with no request pending",
                                  granted_address_o, granted_size_o, status_o));
      end else begin
        got_grant = grants_due.pop_front();
        if (granted_address_o !== got_grant.addr || granted_size_o !== got_grant.size ||
            status_o !== got_grant.status) begin
          report_mismatch($sformatf(
            "grant %0d: addr %h exp %h, size %h exp %h, status %0d exp %0d",
            results_seen, granted_address_o, got_grant.addr, granted_size_o,
            got_grant.size, status_o, got_grant.status));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic post_request(input logic op, input logic [31:0] req_size,
                              input logic [31:0] req_align, input logic [31:0] fixed_addr);
    pending_reqs.push_back('{op: op, req_size: req_size, req_align: req_align,
                             fixed_addr: fixed_addr});
    requests_posted++;
  endtask

  task automatic await_drain();
    wait (results_seen == requests_posted);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_SEG_START) seg_start_q = value;
    else seg_size_q = value;
  endtask

  task automatic set_segment(input logic [31:0] seg_start, input logic [31:0] seg_size);
    await_drain();
    write_cfg(CFG_SEG_START, seg_start);
    write_cfg(CFG_SEG_SIZE, seg_size);
    segments_set++;
  endtask

  // Most settings are windows around recorded blocks, so that searches have
  // to step over blocks and often run out of room.
  task automatic pick_segment();
    bit [63:0]   lo;
    bit [63:0]   hi;
    bit [63:0]   pad;
    bit [31:0]   st;
    bit [31:0]   sz;
    int unsigned sel;
    int unsigned i;
    int unsigned j;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 2))
        0:       st = 32'h0000_0000;
        1:       st = 32'hFFFF_F000;
        default: st = $urandom();
      endcase
      case ($urandom_range(0, 2))
        0:       sz = 32'h0000_0000;
        1:       sz = 32'hFFFF_FFFF;
        default: sz = $urandom();
      endcase
    end else if (sel <= 2) begin
      st = $urandom();
      sz = $urandom();
    end else if (tbl_count == 0) begin
      st = 32'h4000_0000;
      sz = $urandom_range(1, 64) * PAGE;
    end else begin
      i  = $urandom_range(0, tbl_count - 1);
      j  = $urandom_range(0, 1) ? i : $urandom_range(0, tbl_count - 1);
      lo = {44'd0, tbl_base[i]} * PAGE;
      if ({44'd0, tbl_base[j]} * PAGE < lo) lo = {44'd0, tbl_base[j]} * PAGE;
      hi = ({44'd0, tbl_base[i]} + {44'd0, tbl_pages[i]}) * PAGE;
      if (({44'd0, tbl_base[j]} + {44'd0, tbl_pages[j]}) * PAGE > hi)
        hi = ({44'd0, tbl_base[j]} + {44'd0, tbl_pages[j]}) * PAGE;
      pad = 64'($urandom_range(0, 8) * PAGE);
      lo  = (lo >= pad) ? lo - pad : 64'd0;
      hi  = hi + 64'($urandom_range(0, 8) * PAGE);
      st  = lo[31:0];
      if ($urandom_range(0, 3) == 0) st = st | $urandom_range(1, PAGE - 1);
      sz  = (hi - lo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(hi - lo);
    end
    set_segment(st, sz);
  endtask

  function automatic alloc_req_t random_request(input bit compact);
    alloc_req_t  r;
    bit [63:0]   room;
    bit [31:0]   span;
    int unsigned kind;
    int unsigned i;
    room         = segment_end() - {32'd0, seg_start_q};
    span         = (room > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : room[31:0];
    r.op         = OP_ANYWHERE;
    r.req_size   = $urandom();
    r.req_align  = $urandom();
    r.fixed_addr = $urandom();
    kind = compact ? $urandom_range(0, 1) : $urandom_range(0, 3);
    case (kind)
      0:       r.req_size = $urandom_range(0, 4 * PAGE + 64);
      1:       r.req_size = $urandom_range(0, 17 * PAGE);
      2:       r.req_size = $urandom_range(0, span);
      default: ;
    endcase
    kind = compact ? $urandom_range(0, 13) : $urandom_range(0, 15);
    if (kind < 7) begin
      case (compact ? $urandom_range(0, 2) : $urandom_range(0, 5))
        0:       r.req_align = 32'd0;
        1:       r.req_align = $urandom_range(0, PAGE);
        2:       r.req_align = 32'd1 << $urandom_range(12, 18);
        3:       r.req_align = 32'd1 << $urandom_range(19, 31);
        4:       r.req_align = (32'd1 << $urandom_range(13, 31)) | $urandom_range(1, PAGE - 1);
        default: ;
      endcase
    end else if (kind < 14) begin
      r.op = OP_FIXED;
      i    = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
      case ($urandom_range(0, 3))
        0: if (tbl_count > 0)
             r.fixed_addr = {tbl_base[i], 12'd0} + $urandom_range(0, 6 * PAGE) - 3 * PAGE;
        1:       r.fixed_addr = seg_start_q + $urandom_range(0, span);
        2:       r.fixed_addr = seg_start_q + span - $urandom_range(0, 3 * PAGE);
        default: ;
      endcase
    end else begin
      r.op = 1'($urandom_range(0, 1));
    end
    return r;
  endfunction

  // Only the last request of a phase may be granted, so every earlier one is
  // judged against the table as it stands at the start of the phase.
  function automatic alloc_req_t pick_request(input bit want_ok);
    alloc_req_t r;
    grant_t     g;
    int         tries;
    tries = want_ok ? 40 : 12;
    for (int t = 0; t < tries; t++) begin
      r = random_request(want_ok);
      g = plan_grant(r);
      if ((g.status == ST_OK) == want_ok) return r;
    end
    if (want_ok) return r;
    if (tbl_count > 0) begin
      r.op         = OP_FIXED;
      r.fixed_addr = {tbl_base[$urandom_range(0, tbl_count - 1)], 12'd0} |
                     $urandom_range(0, PAGE - 1);
      r.req_size   = $urandom_range(1, PAGE - 1);
    end else begin
      r.op       = OP_ANYWHERE;
      r.req_size = 32'd0;
    end
    return r;
  endfunction

  initial begin
    int         c0;
    int         quota;
    bit         want_ok;
    alloc_req_t r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // After reset the segment is empty.
    post_request(OP_ANYWHERE, 32'h0000_1000, 32'h0000_0000, 32'h0000_0000);
    post_request(OP_FIXED,    32'h0000_1000, 32'h0000_0000, 32'h0000_0000);
    post_request(OP_ANYWHERE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    post_request(OP_FIXED,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

    // Unaligned segment start, one megabyte long.
    set_segment(32'h1000_0123, 32'h0010_0000);
    post_request(OP_ANYWHERE, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    post_request(OP_ANYWHERE, 32'h0000_2001, 32'h0000_8000, 32'hFFFF_FFFF);
    post_request(OP_ANYWHERE, 32'h0000_1000, 32'h0000_1001, 32'h0000_0000);
    post_request(OP_FIXED,    32'h0000_0001, 32'h0000_0000, 32'h1000_8FFF);
    post_request(OP_FIXED,    32'h0000_0001, 32'h0000_0000, 32'h1000_0FFF);
    post_request(OP_FIXED,    32'h0000_1000, 32'h0000_0000, 32'h100F_F000);
    post_request(OP_FIXED,    32'h0000_0900, 32'h0000_0000, 32'h100F_F800);
    post_request(OP_ANYWHERE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    post_request(OP_FIXED,    32'hFFFF_F001, 32'h0000_0000, 32'h0000_0000);
    post_request(OP_ANYWHERE, 32'h0000_1000, 32'h8000_0000, 32'h0000_0000);
    post_request(OP_ANYWHERE, 32'h0000_3000, 32'h0000_6001, 32'h0000_0000);
    post_request(OP_ANYWHERE, 32'h00F0_0000, 32'h0000_0000, 32'h0000_0000);

    // The segment end is clipped at the top of the address space.
    set_segment(32'hFFFF_F000, 32'hFFFF_FFFF);
    post_request(OP_FIXED,    32'h0000_1000, 32'h0000_0000, 32'hFFFF_F000);
    post_request(OP_ANYWHERE, 32'h0000_1000, 32'h0000_0000, 32'h0000_0000);

    // Whole space; earlier blocks still count for overlaps.
    set_segment(32'h0000_0000, 32'hFFFF_FFFF);
    post_request(OP_ANYWHERE, 32'h0000_1000, 32'h0000_0000, 32'h0000_0000);
    post_request(OP_FIXED,    32'h0000_2000, 32'h0000_0000, 32'hFFFF_E000);
    post_request(OP_FIXED,    32'h0000_0010, 32'h0000_0000, 32'h1000_1800);
    post_request(OP_FIXED,    32'h0000_0000, 32'h0000_0000, 32'h1000_2000);
    post_request(OP_FIXED,    32'h0000_0000, 32'h0000_0000, 32'h1000_2001);
    await_drain();
    c0 = tbl_count;

    for (int k = 0; k < PHASES; k++) begin
      pick_segment();
      no_gaps = ($urandom_range(0, 4) == 0);
      quota   = ((k + 1) * (int'(MAX_BLOCKS) - c0)) / FILL_PHASE;
      want_ok = (tbl_count < int'(MAX_BLOCKS)) && ((tbl_count - c0) < quota);
      for (int j = 0; j < PHASE_LEN; j++) begin
        r = pick_request(want_ok && j == PHASE_LEN - 1);
        post_request(r.op, r.req_size, r.req_align, r.fixed_addr);
      end
    end

    await_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (grants_due.size() != 0)
      report_mismatch($sformatf("%0d grants never arrived", grants_due.size()));
    $display("summary: %0d requests over %0d segment settings, %0d granted, %0d with no space",
             requests_taken, segments_set, status_seen[ST_OK], status_seen[ST_NO_SPACE]);
    $display("summary: %0d outside the segment, %0d overlapping, %0d with the table full",
             status_seen[ST_OUTSIDE], status_seen[ST_OVERLAP], status_seen[ST_FULL]);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/sffa_pkg.sv
rtl/sffa_ram.sv
rtl/sffa_ctrl.sv
rtl/segment_first_fit_allocator_top.sv
bench/tb_top.sv
